>>> rtl/htet_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hourly temperature extremes tracker - shared package
// Field widths, reset values and the types passed between the front end,
// the item queue and the back end.
// ----------------------------------------------------------------------------
package htet_pkg;

    localparam int TEMP_W      = 8;
    localparam int SPREAD_W    = 8;
    localparam int PERIOD_W    = 6;
    localparam int SPM_W       = 8;
    localparam int MPP_W       = 6;
    localparam int PPH_W       = 6;
    localparam int QUEUE_DEPTH = 2;

    // Extreme values of the reading range, used to empty the lists.
    localparam logic signed [TEMP_W-1:0] TEMP_LOWEST  = -8'sd128;
    localparam logic signed [TEMP_W-1:0] TEMP_HIGHEST = 8'sd127;

    typedef logic signed [TEMP_W-1:0] t_temp;

    typedef struct packed {
        logic [SPM_W-1:0] sensors_per_minute;
        logic [MPP_W-1:0] minutes_per_period;
        logic [PPH_W-1:0] periods_per_hour;
    } t_cfg;

    // One classified sample on its way to the back end.
    typedef struct packed {
        t_temp               sample;
        logic                period_end;
        logic                hour_end;
        logic [PERIOD_W-1:0] period_num;
    } t_item;

endpackage

>>> rtl/htet_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hourly temperature extremes tracker - front end
// Accepts samples and marks those that close a period or the hour.
// ----------------------------------------------------------------------------
module htet_front import htet_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_push,
    input  t_temp i_sample,
    input  logic  i_full,
    output logic  o_push,
    output t_item o_item
);

    logic [SPM_W-1:0]    r_sample_count, n_sample_count;
    logic [MPP_W-1:0]    r_minute, n_minute;
    logic [PERIOD_W-1:0] r_period_idx, n_period_idx;

    logic [SPM_W-1:0] w_spm_lim;
    logic [MPP_W-1:0] w_mpp_lim;
    logic [PPH_W-1:0] w_pph_lim;
    logic             w_minute_end;
    logic             w_period_end;
    logic             w_hour_end;

    // A zero limit counts as one.
    assign w_spm_lim = (i_cfg.sensors_per_minute == '0) ? SPM_W'(1) : i_cfg.sensors_per_minute;
    assign w_mpp_lim = (i_cfg.minutes_per_period == '0) ? MPP_W'(1) : i_cfg.minutes_per_period;
    assign w_pph_lim = (i_cfg.periods_per_hour == '0) ? PPH_W'(1) : i_cfg.periods_per_hour;

    // A counter at or past its limit minus one closes its span now.
    assign w_minute_end = ({1'b0, r_sample_count} + (SPM_W+1)'(1)) >= {1'b0, w_spm_lim};
    assign w_period_end = w_minute_end
                        && (({1'b0, r_minute} + (MPP_W+1)'(1)) >= {1'b0, w_mpp_lim});
    assign w_hour_end   = w_period_end
                        && (({1'b0, r_period_idx} + (PPH_W+1)'(1)) >= {1'b0, w_pph_lim});

    assign o_push = i_push && !i_full;

    always_comb begin
        o_item.sample     = i_sample;
        o_item.period_end = w_period_end;
        o_item.hour_end   = w_hour_end;
        o_item.period_num = r_period_idx + PERIOD_W'(1);
    end

    always_comb begin
        n_sample_count = r_sample_count;
        n_minute       = r_minute;
        n_period_idx   = r_period_idx;
        if (o_push) begin
            n_sample_count = w_minute_end ? '0 : r_sample_count + SPM_W'(1);
            if (w_minute_end) begin
                n_minute = w_period_end ? '0 : r_minute + MPP_W'(1);
            end
            if (w_period_end) begin
                n_period_idx = w_hour_end ? '0 : r_period_idx + PERIOD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= '0;
            r_minute       <= '0;
            r_period_idx   <= '0;
        end else begin
            r_sample_count <= n_sample_count;
            r_minute       <= n_minute;
            r_period_idx   <= n_period_idx;
        end
    end

endmodule

>>> rtl/htet_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hourly temperature extremes tracker - item queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module htet_queue import htet_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_wr, w_rd;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (w_rd) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

>>> rtl/htet_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hourly temperature extremes tracker - back end
// Sorted insertion into both top lists, period spread tracking and the
// result snapshot that is drained one rank at a time.
// ----------------------------------------------------------------------------
module htet_back import htet_pkg::*; #(
    parameter int LIST_DEPTH = 5,
    localparam int RANK_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_item               i_item,
    output logic                o_pop,
    input  logic                i_res_pop,
    output logic                o_res_empty,
    output logic [RANK_W-1:0]   o_rank,
    output t_temp               o_high_value,
    output t_temp               o_low_value,
    output logic [SPREAD_W-1:0] o_best_spread,
    output logic [PERIOD_W-1:0] o_best_period,
    output logic                o_last
);

    localparam logic [RANK_W-1:0] RANK_LAST = RANK_W'(LIST_DEPTH - 1);

    t_temp r_high [LIST_DEPTH];
    t_temp r_low  [LIST_DEPTH];
    t_temp w_ins_high [LIST_DEPTH];
    t_temp w_ins_low  [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] w_ge, w_le;

    t_temp               r_period_min, r_period_max;
    t_temp               w_min, w_max;
    logic                r_spread_valid;
    logic [SPREAD_W-1:0] r_spread_best, n_spread_best, w_spread;
    logic [PERIOD_W-1:0] r_spread_period, n_spread_period;

    t_temp               r_snap_high [LIST_DEPTH];
    t_temp               r_snap_low  [LIST_DEPTH];
    logic [SPREAD_W-1:0] r_snap_spread;
    logic [PERIOD_W-1:0] r_snap_period;
    logic                r_busy;
    logic [RANK_W-1:0]   r_rank;

    logic w_res_pop, w_snap_free, w_load;

    // Lists stay sorted, so the compare vectors are monotonic and the
    // first set bit is where the new reading goes.
    genvar g;
    generate
        for (g = 0; g < LIST_DEPTH; g++) begin : g_list
            assign w_ge[g] = i_item.sample >= r_high[g];
            assign w_le[g] = i_item.sample <= r_low[g];
            if (g == 0) begin : g_head
                assign w_ins_high[g] = w_ge[g] ? i_item.sample : r_high[g];
                assign w_ins_low[g]  = w_le[g] ? i_item.sample : r_low[g];
            end else begin : g_tail
                assign w_ins_high[g] = !w_ge[g]   ? r_high[g] :
                                       !w_ge[g-1] ? i_item.sample : r_high[g-1];
                assign w_ins_low[g]  = !w_le[g]   ? r_low[g] :
                                       !w_le[g-1] ? i_item.sample : r_low[g-1];
            end
        end
    endgenerate

    assign w_min    = (i_item.sample < r_period_min) ? i_item.sample : r_period_min;
    assign w_max    = (i_item.sample > r_period_max) ? i_item.sample : r_period_max;
    assign w_spread = SPREAD_W'(w_max - w_min);

    always_comb begin
        n_spread_best   = r_spread_best;
        n_spread_period = r_spread_period;
        if (i_item.period_end && (!r_spread_valid || (w_spread > r_spread_best))) begin
            n_spread_best   = w_spread;
            n_spread_period = i_item.period_num;
        end
    end

    assign o_last      = (r_rank == RANK_LAST);
    assign w_res_pop   = i_res_pop && r_busy;
    assign w_snap_free = !r_busy || (w_res_pop && o_last);
    assign o_pop       = i_valid && (!i_item.hour_end || w_snap_free);
    assign w_load      = o_pop && i_item.hour_end;

    assign o_res_empty   = !r_busy;
    assign o_rank        = r_rank;
    assign o_high_value  = r_snap_high[0];
    assign o_low_value   = r_snap_low[0];
    assign o_best_spread = r_snap_spread;
    assign o_best_period = r_snap_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < LIST_DEPTH; m++) begin
                r_high[m] <= TEMP_LOWEST;
                r_low[m]  <= TEMP_HIGHEST;
            end
            r_period_min    <= TEMP_HIGHEST;
            r_period_max    <= TEMP_LOWEST;
            r_spread_valid  <= 1'b0;
            r_spread_best   <= '0;
            r_spread_period <= '0;
            r_busy          <= 1'b0;
            r_rank          <= '0;
        end else begin
            if (o_pop) begin
                if (i_item.hour_end) begin
                    for (int m = 0; m < LIST_DEPTH; m++) begin
                        r_high[m] <= TEMP_LOWEST;
                        r_low[m]  <= TEMP_HIGHEST;
                    end
                    r_period_min    <= TEMP_HIGHEST;
                    r_period_max    <= TEMP_LOWEST;
                    r_spread_valid  <= 1'b0;
                    r_spread_best   <= '0;
                    r_spread_period <= '0;
                end else begin
                    for (int m = 0; m < LIST_DEPTH; m++) begin
                        r_high[m] <= w_ins_high[m];
                        r_low[m]  <= w_ins_low[m];
                    end
                    if (i_item.period_end) begin
                        r_period_min   <= TEMP_HIGHEST;
                        r_period_max   <= TEMP_LOWEST;
                        r_spread_valid <= 1'b1;
                    end else begin
                        r_period_min <= w_min;
                        r_period_max <= w_max;
                    end
                    r_spread_best   <= n_spread_best;
                    r_spread_period <= n_spread_period;
                end
            end
            if (w_load) begin
                r_busy <= 1'b1;
                r_rank <= '0;
            end else if (w_res_pop) begin
                if (o_last) begin
                    r_busy <= 1'b0;
                    r_rank <= '0;
                end else begin
                    r_rank <= r_rank + RANK_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            for (int m = 0; m < LIST_DEPTH; m++) begin
                r_snap_high[m] <= w_ins_high[m];
                r_snap_low[m]  <= w_ins_low[m];
            end
            r_snap_spread <= n_spread_best;
            r_snap_period <= n_spread_period;
        end else if (w_res_pop) begin
            for (int m = 0; m < LIST_DEPTH - 1; m++) begin
                r_snap_high[m] <= r_snap_high[m+1];
                r_snap_low[m]  <= r_snap_low[m+1];
            end
        end
    end

endmodule

>>> rtl/hourly_temperature_extremes_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hourly temperature extremes tracker - top level
// Keeps the largest and smallest readings of each hour and the widest
// per-period spread, and reports them as ranked items at the end of the hour.
// ----------------------------------------------------------------------------
// Throughput: one sample accepted every cycle; the front end never stalls
// while the back end keeps pace, which it does except when an hour ends while
// the previous hour's results have not yet all been popped.
// Results: an hour's last sample is written into the item queue, and the first
// result item of the hour is on the outputs once the back end has taken it and
// loaded the result snapshot; the hour's LIST_DEPTH items are taken one per pop.
// Reset: synchronous, active low; clears counters, lists, spread state and the
// result buffer, and restores the configuration registers to 8, 10 and 6.
// ----------------------------------------------------------------------------
module hourly_temperature_extremes_tracker import htet_pkg::*; #(
    parameter int LIST_DEPTH = 5,
    localparam int RANK_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,

    // Sample side
    input  logic                push,
    output logic                full,
    input  t_temp               i_sample,

    // Result side
    output logic                empty,
    input  logic                pop,
    output logic [RANK_W-1:0]   o_rank,
    output t_temp               o_high_value,
    output t_temp               o_low_value,
    output logic [SPREAD_W-1:0] o_best_spread,
    output logic [PERIOD_W-1:0] o_best_period,
    output logic                o_last
);

    // Register map: one 32-bit word per register.
    localparam logic [1:0] REG_SPM = 2'd0;
    localparam logic [1:0] REG_MPP = 2'd1;
    localparam logic [1:0] REG_PPH = 2'd2;

    t_cfg  r_cfg;
    logic  w_cfg_wr;
    logic  w_front_push;
    t_item w_front_item;
    logic  w_queue_valid;
    t_item w_queue_item;
    logic  w_back_pop;

    // ------------------------------------------------------------------------
    // Configuration registers. The port always completes in its access cycle,
    // and writes to addresses beyond the map are dropped.
    // ------------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensors_per_minute <= SPM_W'(8);
            r_cfg.minutes_per_period <= MPP_W'(10);
            r_cfg.periods_per_hour   <= PPH_W'(6);
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_SPM: r_cfg.sensors_per_minute <= pwdata[SPM_W-1:0];
                REG_MPP: r_cfg.minutes_per_period <= pwdata[MPP_W-1:0];
                REG_PPH: r_cfg.periods_per_hour   <= pwdata[PPH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SPM: prdata = 32'(r_cfg.sensors_per_minute);
            REG_MPP: prdata = 32'(r_cfg.minutes_per_period);
            REG_PPH: prdata = 32'(r_cfg.periods_per_hour);
            default: prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Front end: counts samples into minutes, periods and hours and tags
    // each item with whether it closes a period or the hour.
    // ------------------------------------------------------------------------
    htet_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_push   (push),
        .i_sample (i_sample),
        .i_full   (full),
        .o_push   (w_front_push),
        .o_item   (w_front_item)
    );

    // ------------------------------------------------------------------------
    // Queue between the two halves, so that a back end waiting for the
    // result buffer does not hold up the input at once.
    // ------------------------------------------------------------------------
    htet_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_push),
        .i_item  (w_front_item),
        .o_full  (full),
        .i_pop   (w_back_pop),
        .o_valid (w_queue_valid),
        .o_item  (w_queue_item)
    );

    // ------------------------------------------------------------------------
    // Back end: list insertion, spread tracking and the result buffer. An
    // hour-closing item waits here only while the previous results drain.
    // ------------------------------------------------------------------------
    htet_back #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_queue_valid),
        .i_item        (w_queue_item),
        .o_pop         (w_back_pop),
        .i_res_pop     (pop),
        .o_res_empty   (empty),
        .o_rank        (o_rank),
        .o_high_value  (o_high_value),
        .o_low_value   (o_low_value),
        .o_best_spread (o_best_spread),
        .o_best_period (o_best_period),
        .o_last        (o_last)
    );

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------

    // An empty result buffer always restarts at the top rank.
    a_rank_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        empty |-> (o_rank == '0))
        else $error("rank not at zero while result buffer is empty");

    // Taking a result that is not the final one exposes the next rank.
    a_rank_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_last) |=>
            (!empty && (o_rank == $past(o_rank) + RANK_W'(1))))
        else $error("result rank did not advance after a pop");

    // The result buffer only drains after its final item has been taken.
    a_empty_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(empty) |-> ($past(pop) && $past(o_last)))
        else $error("result buffer emptied before its final item was taken");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hourly temperature extremes tracker - self-checking testbench
// Feeds temperature readings through the push/full side, programmes the three
// counting registers over the APB-style port between phases, and checks every
// ranked end-of-hour item against a cycle-free model of the hourly lists,
// the per-period spread and the minute, period and hour counters.
// ----------------------------------------------------------------------------
module tb_top import htet_pkg::*; ();

    localparam int    LIST_DEPTH   = 5;
    localparam int    CLK_HALF     = 6;
    localparam int    STALL_CYCLES = 400;
    localparam int    IDLE_LIMIT   = 3000;
    localparam int    SETTLE       = 8;
    localparam int    PHASE_ITEMS  = 48;
    localparam int    RAND_PHASES  = 8;

    // Register indexes of the configuration port; index 3 is not decoded.
    localparam int    REG_SPM    = 0;
    localparam int    REG_MPP    = 1;
    localparam int    REG_PPH    = 2;
    localparam int    REG_UNUSED = 3;

    // One ranked item of an hour's report, as the block should present it.
    typedef struct {
        logic [2:0]          rank;
        t_temp               high_value;
        t_temp               low_value;
        logic [SPREAD_W-1:0] best_spread;
        logic [PERIOD_W-1:0] best_period;
        logic                last;
    } t_hour_report;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [3:0]          paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                push    = 1'b0;
    logic                full;
    t_temp               i_sample = '0;
    logic                empty;
    logic                pop     = 1'b0;
    logic [2:0]          o_rank;
    t_temp               o_high_value;
    t_temp               o_low_value;
    logic [SPREAD_W-1:0] o_best_spread;
    logic [PERIOD_W-1:0] o_best_period;
    logic                o_last;

    hourly_temperature_extremes_tracker #(.LIST_DEPTH(LIST_DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .i_sample      (i_sample),
        .empty         (empty),
        .pop           (pop),
        .o_rank        (o_rank),
        .o_high_value  (o_high_value),
        .o_low_value   (o_low_value),
        .o_best_spread (o_best_spread),
        .o_best_period (o_best_period),
        .o_last        (o_last)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Model of the block. The register shadows follow every write on the
    // configuration port; the hourly state follows every accepted reading.
    // ------------------------------------------------------------------------
    logic [SPM_W-1:0]    shadow_spm = 8'd8;
    logic [MPP_W-1:0]    shadow_mpp = 6'd10;
    logic [PPH_W-1:0]    shadow_pph = 6'd6;

    t_temp               hour_high [LIST_DEPTH];
    t_temp               hour_low  [LIST_DEPTH];
    t_temp               win_min;
    t_temp               win_max;
    logic                spread_seen;
    logic [SPREAD_W-1:0] widest_spread;
    logic [PERIOD_W-1:0] widest_period;
    int                  reading_in_minute;
    int                  minute_in_window;
    int                  window_in_hour;

    t_hour_report        pending_reports [$];
    t_temp               readings_q [$];

    int                  err_count    = 0;
    int                  n_readings   = 0;
    int                  n_reports    = 0;
    int                  n_hours      = 0;
    bit                  no_gaps      = 1'b0;
    bit                  hold_results = 1'b0;
    int                  hold_count   = 0;
    int                  quiet_cycles = 0;

    function automatic void clear_hour_state();
        for (int k = 0; k < LIST_DEPTH; k++) begin
            hour_high[k] = TEMP_LOWEST;
            hour_low[k]  = TEMP_HIGHEST;
        end
        win_min           = TEMP_HIGHEST;
        win_max           = TEMP_LOWEST;
        spread_seen       = 1'b0;
        widest_spread     = '0;
        widest_period     = '0;
        reading_in_minute = 0;
        minute_in_window  = 0;
        window_in_hour    = 0;
    endfunction

    // A register holding zero counts as one.
    function automatic int count_limit(int reg_value);
        return (reg_value == 0) ? 1 : reg_value;
    endfunction

    // Works out what one accepted reading does to the hourly state and queues
    // the hour's report when the reading closes the hour.
    function automatic void take_reading(t_temp v);
        bit           placed;
        int           spread;
        t_hour_report rpt;

        if (v < win_min) win_min = v;
        if (v > win_max) win_max = v;

        // A new reading goes in ahead of an equal entry; the tail moves down.
        placed = 1'b0;
        for (int k = 0; k < LIST_DEPTH; k++) begin
            if (!placed && v >= hour_high[k]) begin
                for (int m = LIST_DEPTH - 1; m > k; m--) hour_high[m] = hour_high[m-1];
                hour_high[k] = v;
                placed = 1'b1;
            end
        end
        placed = 1'b0;
        for (int k = 0; k < LIST_DEPTH; k++) begin
            if (!placed && v <= hour_low[k]) begin
                for (int m = LIST_DEPTH - 1; m > k; m--) hour_low[m] = hour_low[m-1];
                hour_low[k] = v;
                placed = 1'b1;
            end
        end

        // A counter at or past its limit closes on this reading, which covers
        // a register lowered while the count was already beyond it.
        if (reading_in_minute + 1 < count_limit(shadow_spm)) begin
            reading_in_minute++;
            return;
        end
        reading_in_minute = 0;
        if (minute_in_window + 1 < count_limit(shadow_mpp)) begin
            minute_in_window++;
            return;
        end
        minute_in_window = 0;

        // The first period of the hour is always kept; later ones only if wider.
        spread = (int'(win_max) - int'(win_min)) & 8'hFF;
        if (!spread_seen || spread > widest_spread) begin
            widest_spread = spread[SPREAD_W-1:0];
            widest_period = PERIOD_W'(window_in_hour + 1);
            spread_seen   = 1'b1;
        end
        win_min = TEMP_HIGHEST;
        win_max = TEMP_LOWEST;

        if (window_in_hour + 1 < count_limit(shadow_pph)) begin
            window_in_hour++;
            return;
        end

        for (int k = 0; k < LIST_DEPTH; k++) begin
            rpt.rank        = 3'(k);
            rpt.high_value  = hour_high[k];
            rpt.low_value   = hour_low[k];
            rpt.best_spread = widest_spread;
            rpt.best_period = widest_period;
            rpt.last        = (k == LIST_DEPTH - 1);
            pending_reports.push_back(rpt);
        end
        n_hours++;
        clear_hour_state();
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
        err_count++;
    endtask

    // ------------------------------------------------------------------------
    // Sample driver. The slot holds one item; it is refilled from the pending
    // queue once the current item has been taken, or left empty on an idle
    // cycle. Prediction happens on the edge at which the block takes the item.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push     <= 1'b0;
            i_sample <= '0;
        end else begin
            if (push && !full) begin
                take_reading(i_sample);
                n_readings++;
            end
            if (!push || !full) begin
                if (readings_q.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 30)) begin
                    push     <= 1'b1;
                    i_sample <= readings_q.pop_front();
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side. Pop is withdrawn at random; once in the run it is held low
    // for a long stretch so that the result buffer and the item queue fill up
    // and the block has to raise full.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_results && hold_count < STALL_CYCLES) begin
            hold_count <= hold_count + 1;
            pop        <= 1'b0;
        end else begin
            pop <= no_gaps || ($urandom_range(0, 99) >= 30);
        end
    end

    // Every item taken from the result side is held against the oldest report
    // still owed, field by field.
    always @(posedge i_clk) begin
        t_hour_report want;
        if (i_rst_n && pop && !empty) begin
            if (pending_reports.size() == 0) begin
                report_mismatch("result item with none owed, rank", o_rank, -1);
            end else begin
                want = pending_reports.pop_front();
                n_reports++;
                if (o_rank !== want.rank)
                    report_mismatch("rank", o_rank, want.rank);
                if (o_high_value !== want.high_value)
                    report_mismatch("high_value", o_high_value, want.high_value);
                if (o_low_value !== want.low_value)
                    report_mismatch("low_value", o_low_value, want.low_value);
                if (o_best_spread !== want.best_spread)
                    report_mismatch("best_spread", o_best_spread, want.best_spread);
                if (o_best_period !== want.best_period)
                    report_mismatch("best_period", o_best_period, want.best_period);
                if (o_last !== want.last)
                    report_mismatch("last", o_last, want.last);
            end
        end
    end

    // Watchdog: a run in which nothing moves on either side for too long has
    // hung. The long result stall is well inside this limit.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("hourly_temperature_extremes_tracker: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Configuration and stimulus sequencing.
    // ------------------------------------------------------------------------

    // Setup cycle, then access cycle; the register takes the value at the
    // edge that ends the access cycle.
    task automatic write_register(int index, int value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(4 * index);
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_SPM: shadow_spm = SPM_W'(value);
            REG_MPP: shadow_mpp = MPP_W'(value);
            REG_PPH: shadow_pph = PPH_W'(value);
            default: ;
        endcase
    endtask

    task automatic set_counts(int spm, int mpp, int pph);
        write_register(REG_SPM, spm);
        write_register(REG_MPP, mpp);
        write_register(REG_PPH, pph);
    endtask

    // Waits until every pending item has been taken and every owed report has
    // arrived, then lets a partly classified hour settle inside the block.
    task automatic wait_until_idle();
        while (readings_q.size() > 0 || push || pending_reports.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        int reading;
        clear_hour_state();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed part. Two readings a minute, two minutes a period, three
        // periods an hour: twelve readings close the hour. The first two
        // periods have the same spread, so the earlier one must be kept; the
        // third reaches both ends of the byte and must win.
        set_counts(2, 2, 3);
        readings_q = {8'sd10, 8'sd20, 8'sd10, 8'sd20, 8'sd5, 8'sd15, 8'sd5, 8'sd15,
                      8'sd70, -8'sd100, 8'sd127, -8'sd128};
        wait_until_idle();

        // One reading per period, two periods an hour: equal readings give a
        // spread of zero in every period, and the first period still counts.
        // Lists only partly filled also show their empty markers.
        set_counts(1, 1, 2);
        readings_q = {8'sd0, 8'sd0, -8'sd1, -8'sd1};
        wait_until_idle();

        // Zero in every register counts as one, so each reading ends an hour.
        // A write to the undecoded index must change nothing.
        set_counts(0, 0, 0);
        write_register(REG_UNUSED, 7);
        readings_q = {8'sd70, -8'sd100, 8'sd33};
        wait_until_idle();

        // Full lists: a reading below every entry of the largest list, and
        // one above every entry of the smallest list, leave those lists alone.
        set_counts(1, 1, 8);
        readings_q = {8'sd40, 8'sd50, 8'sd60, 8'sd45, 8'sd55, -8'sd90, 8'sd50, 8'sd65};
        wait_until_idle();

        // Random part. Each phase draws short counts so that hours end often;
        // some phases use a narrow band of readings to force ties in the lists.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            no_gaps = (ph == 2);
            if (ph == 4) begin
                // Every reading closes an hour while pop is held low for a
                // long stretch: the block must fill up and push back.
                set_counts(1, 1, 1);
                hold_results = 1'b1;
            end else if (ph == 6) begin
                // Counts of 255, 60 and 60; the hour never completes. Lowering all
                // three afterwards must close the hour on the next reading.
                set_counts(255, 60, 60);
                for (int n = 0; n < 40; n++)
                    readings_q.push_back(t_temp'($urandom_range(0, 170) - 100));
                wait_until_idle();
                set_counts(1, 1, 1);
            end else begin
                set_counts($urandom_range(1, 4), $urandom_range(1, 3), $urandom_range(1, 4));
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph % 3 == 1)
                    reading = $urandom_range(0, 6) - 3;
                else if ($urandom_range(0, 15) == 0)
                    reading = $urandom_range(0, 255);
                else
                    reading = $urandom_range(0, 170) - 100;
                readings_q.push_back(t_temp'(reading));
            end
            wait_until_idle();
            hold_results = 1'b0;
        end

        no_gaps = 1'b0;
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d readings over %0d completed hours, %0d ranked items checked",
                 n_readings, n_hours, n_reports);
        $display("counts from zero to the largest, a long result stall, %0d mismatches",
                 err_count);
        if (err_count == 0 && pending_reports.size() == 0) begin
            $display("hourly_temperature_extremes_tracker: match");
        end else begin
            $display("hourly_temperature_extremes_tracker: mismatch");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/htet_pkg.sv
rtl/htet_front.sv
rtl/htet_queue.sv
rtl/htet_back.sv
rtl/hourly_temperature_extremes_tracker.sv
test/tb_top.sv
